>>> design/vdt_pkg.sv
// vdt_pkg: shared types, operation codes and sizing constants for the
// vertex deduplication table. No dependencies; compiled first.
package vdt_pkg;

  // Default table size (entries) and fixed field widths
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int COORD_W         = 32;
  localparam int OP_W            = 2;
  localparam int RIDX_W          = 10;
  localparam int VIDX_W          = 10;
  localparam int TOTAL_W         = 11;

  // Operation codes; code 3 is unused and only reports the count
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_SUBMIT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;          // latch the accepted transaction
    logic scan_en;       // step the linear search one entry
    logic rd_idx_en;     // read the entry named by read_index
    logic latch_search;  // capture search outcome
    logic commit;        // update table and result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;  // operation of the latched transaction
    logic            hit;   // compared entry matches
    logic            miss;  // search exhausted without a match
  } stat_t;

endpackage

>>> design/vdt_chan_if.sv
// vdt_chan_if: valid/ready channel interfaces for the input and result
// transactions of the vertex deduplication table. Depends on vdt_pkg.
interface vdt_in_if;
  import vdt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [RIDX_W-1:0]         read_index;

  modport source (output valid, operation, coord_x, coord_y, coord_z, read_index,
                  input ready);
  modport sink   (input valid, operation, coord_x, coord_y, coord_z, read_index,
                  output ready);
endinterface

interface vdt_out_if;
  import vdt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [VIDX_W-1:0]         vertex_index;
  logic                      was_new;
  logic                      table_full;
  logic [TOTAL_W-1:0]        entry_total;
  logic signed [COORD_W-1:0] read_x;
  logic signed [COORD_W-1:0] read_y;
  logic signed [COORD_W-1:0] read_z;
  logic                      index_invalid;

  modport source (output valid, vertex_index, was_new, table_full, entry_total,
                  read_x, read_y, read_z, index_invalid, input ready);
  modport sink   (input valid, vertex_index, was_new, table_full, entry_total,
                  read_x, read_y, read_z, index_invalid, output ready);
endinterface

>>> design/vdt_ctrl.sv
// vdt_ctrl: sequencing state machine of the vertex deduplication table.
// Drives the handshakes and the datapath commands. Depends on vdt_pkg.
module vdt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  vdt_pkg::stat_t stat,
  output vdt_pkg::cmd_t  cmd
);
  import vdt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE) && rst_n;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  // result register can take a new result this cycle
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        // route by the operation latched on accept
        unique case (stat.op)
          OP_SUBMIT: state_nxt = S_SCAN;
          OP_READ:   state_nxt = S_READ;
          default:   state_nxt = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (stat.hit || stat.miss) begin
          cmd.latch_search = 1'b1;
          state_nxt        = S_FINISH;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd_idx_en = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/vdt_datapath.sv
// vdt_datapath: vertex store memory, search counter, comparator, stored
// count and result register of the vertex deduplication table. Depends on vdt_pkg.
module vdt_datapath #(
  parameter int TABLE_DEPTH = vdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vdt_pkg::cmd_t                      cmd,
  output vdt_pkg::stat_t                     stat,
  input  logic [vdt_pkg::OP_W-1:0]           in_operation,
  input  logic signed [vdt_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [vdt_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [vdt_pkg::COORD_W-1:0] in_coord_z,
  input  logic [vdt_pkg::RIDX_W-1:0]         in_read_index,
  output logic [vdt_pkg::VIDX_W-1:0]         out_vertex_index,
  output logic                               out_was_new,
  output logic                               out_table_full,
  output logic [vdt_pkg::TOTAL_W-1:0]        out_entry_total,
  output logic signed [vdt_pkg::COORD_W-1:0] out_read_x,
  output logic signed [vdt_pkg::COORD_W-1:0] out_read_y,
  output logic signed [vdt_pkg::COORD_W-1:0] out_read_z,
  output logic                               out_index_invalid
);
  import vdt_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 3 * COORD_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  // vertex store: contents undefined until written, only entries below
  // the stored count are ever used in a result
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // latched transaction
  logic [OP_W-1:0]    op_r;
  logic [ENTRY_W-1:0] key_r;
  logic [RIDX_W-1:0]  ridx_r;

  // search state
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   scan_r;
  logic               chk_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               hit_r;
  logic [IDX_W-1:0]   found_r;

  logic               scan_issue;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               hit;
  logic               read_ok;

  // result next values
  logic [31:0]        vi_nxt;
  logic [31:0]        total_nxt;
  logic               new_nxt, full_nxt, inval_nxt, we;
  logic [ENTRY_W-1:0] rd_nxt;

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      key_r  <= {in_coord_x, in_coord_y, in_coord_z};
      ridx_r <= in_read_index;
    end
  end

  // linear search counter: issue one read per cycle, compare the read data in the cycle after
  assign scan_issue = cmd.scan_en && (scan_r != count_r);
  assign hit        = chk_r && (rd_data_r == key_r);
  assign read_ok    = {{(32-RIDX_W){1'b0}}, ridx_r} < 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      chk_r  <= 1'b0;
    end else if (cmd.load) begin
      scan_r <= '0;
      chk_r  <= 1'b0;
    end else if (cmd.scan_en) begin
      chk_r <= scan_issue;
      if (scan_issue) begin
        scan_r <= scan_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      chk_idx_r <= scan_r[IDX_W-1:0];
    end
    if (cmd.latch_search) begin
      hit_r   <= hit;
      found_r <= chk_idx_r;
    end
  end

  assign stat.op   = op_r;
  assign stat.hit  = hit;
  assign stat.miss = (scan_r == count_r) && !hit;

  // single read port: search address or read-back address
  assign rd_en   = scan_issue || cmd.rd_idx_en;
  assign rd_addr = cmd.rd_idx_en ? IDX_W'(ridx_r) : scan_r[IDX_W-1:0];

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && we) begin
      mem[count_r[IDX_W-1:0]] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result and table update for the latched operation
  always_comb begin
    vi_nxt    = '0;
    total_nxt = 32'(count_r);
    new_nxt   = 1'b0;
    full_nxt  = 1'b0;
    inval_nxt = 1'b0;
    rd_nxt    = '0;
    we        = 1'b0;
    count_nxt = count_r;
    unique case (op_r)
      OP_CLEAR: begin
        total_nxt = '0;
        count_nxt = '0;
      end
      OP_SUBMIT: begin
        if (hit_r) begin
          vi_nxt = 32'(found_r);
        end else if (count_r != FULL_CNT) begin
          we        = 1'b1;
          vi_nxt    = 32'(count_r);
          new_nxt   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          total_nxt = 32'(count_r) + 32'd1;
        end else begin
          full_nxt = 1'b1;
        end
      end
      OP_READ: begin
        vi_nxt = 32'(ridx_r);
        if (read_ok) begin
          rd_nxt = rd_data_r;
        end else begin
          inval_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_vertex_index  <= vi_nxt[VIDX_W-1:0];
      out_was_new       <= new_nxt;
      out_table_full    <= full_nxt;
      out_entry_total   <= total_nxt[TOTAL_W-1:0];
      out_read_x        <= rd_nxt[3*COORD_W-1:2*COORD_W];
      out_read_y        <= rd_nxt[2*COORD_W-1:COORD_W];
      out_read_z        <= rd_nxt[COORD_W-1:0];
      out_index_invalid <= inval_nxt;
    end
  end

endmodule

>>> design/vertex_dedup_table.sv
// vertex_dedup_table: top level of the vertex deduplication table.
// Instantiates vdt_ctrl and vdt_datapath; depends on vdt_pkg and vdt_chan_if.
//
// Usage:
//   in_chan carries one transaction per item: operation (clear, submit,
//   read-back), three signed Q2.30 coordinates and a read index. out_chan
//   returns exactly one result per item, in order.
//   Submit scans the stored vertices in insertion order, one entry per
//   cycle through the single read port of the vertex store; a hit returns
//   the first matching index, a miss appends the vertex unless the table
//   is full, in which case table_full is flagged instead.
//   Each item passes from accept through a dispatch state, then the scan
//   (submit) or a memory read (read-back), to a finish state that writes
//   the result register; clear and unused code 3 skip the middle step.
//   A new item is accepted only once the previous one has reached the
//   result register.
//   Reset clears the stored count; the store itself needs no clearing.
//   While the receiver stalls, the result is held and one further item
//   may be accepted and processed; it then waits for the result register.
module vertex_dedup_table #(
  parameter int TABLE_DEPTH = vdt_pkg::TABLE_DEPTH_DEF
) (
  input logic clk,
  input logic rst_n,
  vdt_in_if.sink    in_chan,
  vdt_out_if.source out_chan
);
  import vdt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  vdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vdt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_chan.operation),
    .in_coord_x        (in_chan.coord_x),
    .in_coord_y        (in_chan.coord_y),
    .in_coord_z        (in_chan.coord_z),
    .in_read_index     (in_chan.read_index),
    .out_vertex_index  (out_chan.vertex_index),
    .out_was_new       (out_chan.was_new),
    .out_table_full    (out_chan.table_full),
    .out_entry_total   (out_chan.entry_total),
    .out_read_x        (out_chan.read_x),
    .out_read_y        (out_chan.read_y),
    .out_read_z        (out_chan.read_z),
    .out_index_invalid (out_chan.index_invalid)
  );

`ifndef SYNTHESIS
  // a commit never overwrites a result that has not been taken
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten");

  // a commit always presents a result next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_chan.valid)
    else $error("committed result not presented");

  // the block is busy right after accepting a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("accepted while busy");

  // search commands never overlap a commit
  a_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit && (cmd.scan_en || cmd.latch_search)))
    else $error("search and commit overlap");
`endif

endmodule

>>> sim/vertex_dedup_table_tb.sv
`timescale 1ns / 1ps
// vertex_dedup_table_tb: self-checking bench for the vertex deduplication table.
// Depends on vdt_pkg, vdt_chan_if and vertex_dedup_table; predicts every lookup.
module vertex_dedup_table_tb;
  import vdt_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int MAX_IDLE     = 13;
  localparam int RANDOM_ITEMS = 550;
  localparam int SETTLE_LIMIT = 4 * DEPTH + 200;
  localparam int TIMEOUT_NS   = 60_000_000;

  // Unused operation code: reports the count only
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Q2.30 corner values
  localparam logic signed [COORD_W-1:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_ONE     = 32'sh4000_0000;
  localparam logic signed [COORD_W-1:0] Q_LSB     = 32'sh0000_0001;
  localparam logic signed [COORD_W-1:0] Q_NEG_LSB = 32'shFFFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [RIDX_W-1:0]         read_index;
  } vtx_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]         vertex_index;
    logic                      was_new;
    logic                      table_full;
    logic [TOTAL_W-1:0]        entry_total;
    logic signed [COORD_W-1:0] read_x;
    logic signed [COORD_W-1:0] read_y;
    logic signed [COORD_W-1:0] read_z;
    logic                      index_invalid;
  } lookup_result_t;

  // One directed step; gold holds a hand-written result when gold_known is set
  typedef struct {
    vtx_item_t      stim;
    bit             gold_known;
    lookup_result_t gold;
  } mesh_row_t;

  logic clk;
  logic rst_n;
  bit   quiet;
  int unsigned fault_count;

  // Lookups in flight, oldest first
  lookup_result_t pending_lookups[$];

  // Directed stimulus table
  mesh_row_t directed_rows[$];

  // Shadow copy of the unique-vertex table
  logic signed [COORD_W-1:0] mesh_x [DEPTH];
  logic signed [COORD_W-1:0] mesh_y [DEPTH];
  logic signed [COORD_W-1:0] mesh_z [DEPTH];
  logic [TOTAL_W-1:0]        shadow_count;

  vdt_in_if  in_chan ();
  vdt_out_if out_chan ();

  vertex_dedup_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("vertex_dedup_table_tb: FAIL");
    $finish;
  end

  function automatic vtx_item_t item_of(input logic [OP_W-1:0] op,
                                        input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic signed [COORD_W-1:0] z,
                                        input logic [RIDX_W-1:0] ridx);
    vtx_item_t it;
    it.operation  = op;
    it.coord_x    = x;
    it.coord_y    = y;
    it.coord_z    = z;
    it.read_index = ridx;
    return it;
  endfunction

  function automatic lookup_result_t result_of(input logic [VIDX_W-1:0] vi,
                                               input logic fresh,
                                               input logic full,
                                               input logic [TOTAL_W-1:0] total,
                                               input logic signed [COORD_W-1:0] rx,
                                               input logic signed [COORD_W-1:0] ry,
                                               input logic signed [COORD_W-1:0] rz,
                                               input logic invalid);
    lookup_result_t r;
    r.vertex_index  = vi;
    r.was_new       = fresh;
    r.table_full    = full;
    r.entry_total   = total;
    r.read_x        = rx;
    r.read_y        = ry;
    r.read_z        = rz;
    r.index_invalid = invalid;
    return r;
  endfunction

  function automatic mesh_row_t mesh_row(input vtx_item_t s, input bit known,
                                         input lookup_result_t g);
    mesh_row_t row;
    row.stim       = s;
    row.gold_known = known;
    row.gold       = g;
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void queue_row(input mesh_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // Behavioral lookup: updates the shadow table and returns the result
  function automatic lookup_result_t predict_lookup(input vtx_item_t it);
    lookup_result_t r;
    int hit_at;
    int j;
    r      = '0;
    hit_at = -1;
    j      = 0;
    case (it.operation)
      OP_CLEAR: shadow_count = '0;
      OP_SUBMIT: begin
        // first exact match in insertion order wins
        while (hit_at < 0 && j < shadow_count) begin
          if (mesh_x[j] == it.coord_x && mesh_y[j] == it.coord_y &&
              mesh_z[j] == it.coord_z)
            hit_at = j;
          j++;
        end
        if (hit_at >= 0) begin
          r.vertex_index = hit_at[VIDX_W-1:0];
        end else if (shadow_count < DEPTH) begin
          mesh_x[shadow_count] = it.coord_x;
          mesh_y[shadow_count] = it.coord_y;
          mesh_z[shadow_count] = it.coord_z;
          r.vertex_index = shadow_count[VIDX_W-1:0];
          r.was_new      = 1'b1;
          shadow_count++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      OP_READ: begin
        r.vertex_index = it.read_index;
        if (it.read_index < shadow_count) begin
          r.read_x = mesh_x[it.read_index];
          r.read_y = mesh_y[it.read_index];
          r.read_z = mesh_z[it.read_index];
        end else begin
          r.index_invalid = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_total = shadow_count;
    return r;
  endfunction

  // Coarse lattice of coordinates so that random corners collide often
  function automatic logic signed [COORD_W-1:0] grid_coord();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return Q_ONE;
      4:       return -Q_ONE;
      5:       return Q_NEG_LSB;
      6:       return 32'sh2000_0000;
      default: return Q_LSB;
    endcase
  endfunction

  // Mostly mesh-like traffic: revisited corners, near misses, lattice points
  function automatic vtx_item_t draw_mesh_item();
    vtx_item_t it;
    int roll;
    int pick;
    int flip;
    it.operation  = OP_SUBMIT;
    it.coord_x    = $urandom;
    it.coord_y    = $urandom;
    it.coord_z    = $urandom;
    it.read_index = RIDX_W'($urandom_range(0, 1023));
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      it.operation = OP_CLEAR;
    end else if (roll < 7) begin
      it.operation = OP_SPARE;
    end else if (roll < 27) begin
      it.operation = OP_READ;
      if (shadow_count != 0 && $urandom_range(0, 3) != 0)
        it.read_index = RIDX_W'($urandom_range(0, shadow_count - 1));
    end else begin
      roll = $urandom_range(0, 9);
      pick = (shadow_count != 0) ? $urandom_range(0, shadow_count - 1) : 0;
      if (roll < 6 && shadow_count != 0) begin
        it.coord_x = mesh_x[pick];
        it.coord_y = mesh_y[pick];
        it.coord_z = mesh_z[pick];
        // near miss: one coordinate off by a single bit
        if (roll >= 4) begin
          flip = $urandom_range(0, COORD_W - 1);
          case ($urandom_range(0, 2))
            0:       it.coord_x[flip] = ~it.coord_x[flip];
            1:       it.coord_y[flip] = ~it.coord_y[flip];
            default: it.coord_z[flip] = ~it.coord_z[flip];
          endcase
        end
      end else if (roll < 8) begin
        it.coord_x = grid_coord();
        it.coord_y = grid_coord();
        it.coord_z = grid_coord();
      end
    end
    return it;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fault_count++;
    end
  endtask

  task automatic check_lookup(input lookup_result_t want, input lookup_result_t got);
    check_field("vertex_index", 64'(want.vertex_index), 64'(got.vertex_index));
    check_field("was_new", 64'(want.was_new), 64'(got.was_new));
    check_field("table_full", 64'(want.table_full), 64'(got.table_full));
    check_field("entry_total", 64'(want.entry_total), 64'(got.entry_total));
    check_field("read_x", 64'(want.read_x), 64'(got.read_x));
    check_field("read_y", 64'(want.read_y), 64'(got.read_y));
    check_field("read_z", 64'(want.read_z), 64'(got.read_z));
    check_field("index_invalid", 64'(want.index_invalid), 64'(got.index_invalid));
  endtask

  // Present one transaction after a random gap; predict it once accepted
  task automatic send_item(input vtx_item_t it, input bit gold_known,
                           input lookup_result_t gold);
    int gap;
    lookup_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= it.operation;
    in_chan.coord_x    <= it.coord_x;
    in_chan.coord_y    <= it.coord_y;
    in_chan.coord_z    <= it.coord_z;
    in_chan.read_index <= it.read_index;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predicted = predict_lookup(it);
    if (gold_known)
      predicted = gold;
    pending_lookups = {pending_lookups, predicted};
  endtask

  // Hold off the sender until every lookup in flight has returned or the wait limit runs out
  task automatic settle_results();
    int waited;
    waited = 0;
    in_chan.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_lookups.size() != 0 && waited < SETTLE_LIMIT);
  endtask

  // Result side: random back-pressure, check each transaction in order
  initial begin : result_sink
    int stall;
    lookup_result_t got;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      got.vertex_index  = out_chan.vertex_index;
      got.was_new       = out_chan.was_new;
      got.table_full    = out_chan.table_full;
      got.entry_total   = out_chan.entry_total;
      got.read_x        = out_chan.read_x;
      got.read_y        = out_chan.read_y;
      got.read_z        = out_chan.read_z;
      got.index_invalid = out_chan.index_invalid;
      if (pending_lookups.size() == 0) begin
        $error("result transaction with no lookup pending");
        fault_count++;
      end else begin
        check_lookup(pending_lookups.pop_front(), got);
      end
    end
  end

  // Stimulus: directed rows, random mesh traffic, then a short closing sequence
  initial begin : stimulus
    int n;
    in_chan.valid      <= 1'b0;
    in_chan.operation  <= OP_CLEAR;
    in_chan.coord_x    <= '0;
    in_chan.coord_y    <= '0;
    in_chan.coord_z    <= '0;
    in_chan.read_index <= '0;
    rst_n              <= 1'b0;
    quiet        = 1'b0;
    fault_count  = 0;
    shadow_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: reads are out of range, spare code and clear report zero
    queue_row(mesh_row(item_of(OP_READ, '0, '0, '0, '0), 1'b1,
              result_of('0, 0, 0, 0, '0, '0, '0, 1)));
    queue_row(mesh_row(item_of(OP_READ, Q_MAX, Q_MIN, Q_MAX, 10'h3FF), 1'b1,
              result_of(10'h3FF, 0, 0, 0, '0, '0, '0, 1)));
    queue_row(mesh_row(item_of(OP_SPARE, Q_MIN, Q_MAX, Q_ONE, 10'h3FF), 1'b1,
              result_of('0, 0, 0, 0, '0, '0, '0, 0)));
    queue_row(mesh_row(item_of(OP_CLEAR, Q_MAX, Q_MAX, Q_MAX, 10'h3FF), 1'b1,
              result_of('0, 0, 0, 0, '0, '0, '0, 0)));
    // coordinate extremes, then hits and a partial match
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_MIN, Q_MIN, Q_MIN, '0), 1'b1,
              result_of(10'd0, 1, 0, 11'd1, '0, '0, '0, 0)));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_MAX, Q_MAX, Q_MAX, '0), 1'b1,
              result_of(10'd1, 1, 0, 11'd2, '0, '0, '0, 0)));
    queue_row(mesh_row(item_of(OP_SUBMIT, '0, '0, '0, '0), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB,
              10'h3FF), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_MIN, Q_MIN, Q_MIN, '0), 1'b1,
              result_of(10'd0, 0, 0, 11'd4, '0, '0, '0, 0)));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_MIN, Q_MIN, Q_MAX, '0), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_MAX, Q_MIN, Q_ONE, 10'h3FF), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_MAX, Q_MIN, Q_ONE, '0), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_MAX, Q_MAX, Q_MAX, '0), 1'b1,
              result_of(10'd1, 0, 0, 11'd6, '0, '0, '0, 0)));
    // read back, in range and just past the end
    queue_row(mesh_row(item_of(OP_READ, '0, '0, '0, 10'd0), 1'b1,
              result_of(10'd0, 0, 0, 11'd6, Q_MIN, Q_MIN, Q_MIN, 0)));
    queue_row(mesh_row(item_of(OP_READ, Q_ONE, Q_MIN, Q_LSB, 10'd1), 1'b1,
              result_of(10'd1, 0, 0, 11'd6, Q_MAX, Q_MAX, Q_MAX, 0)));
    queue_row(mesh_row(item_of(OP_READ, '0, '0, '0, 10'd5), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_READ, '0, '0, '0, 10'd6), 1'b1,
              result_of(10'd6, 0, 0, 11'd6, '0, '0, '0, 1)));
    queue_row(mesh_row(item_of(OP_SPARE, Q_NEG_LSB, Q_ONE, Q_MAX, 10'd2), 1'b1,
              result_of('0, 0, 0, 11'd6, '0, '0, '0, 0)));
    // clear drops every entry
    queue_row(mesh_row(item_of(OP_CLEAR, '0, '0, '0, '0), 1'b1,
              result_of('0, 0, 0, 0, '0, '0, '0, 0)));
    queue_row(mesh_row(item_of(OP_READ, '0, '0, '0, 10'd0), 1'b1,
              result_of(10'd0, 0, 0, 0, '0, '0, '0, 1)));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_ONE, -Q_ONE, '0, 10'h155), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_SUBMIT, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB,
              10'h2AA), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_READ, Q_MAX, Q_MAX, Q_MAX, 10'd1), 1'b0, '0));
    queue_row(mesh_row(item_of(OP_SUBMIT, '0, '0, Q_LSB, '0), 1'b0, '0));

    foreach (directed_rows[r])
      send_item(directed_rows[r].stim, directed_rows[r].gold_known, directed_rows[r].gold);
    settle_results();

    // random mesh traffic, with bursts free of idling
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      send_item(draw_mesh_item(), 1'b0, '0);
      if ($urandom_range(0, 59) == 0) settle_results();
    end
    quiet = 1'b0;
    settle_results();

    // clear, the last index reads back as out of range, then a miss and a hit
    send_item(item_of(OP_CLEAR, '0, '0, '0, '0), 1'b0, '0);
    send_item(item_of(OP_READ, '0, '0, '0, RIDX_W'(DEPTH - 1)), 1'b0, '0);
    send_item(item_of(OP_SUBMIT, Q_MAX, Q_MIN, Q_MAX, '0), 1'b0, '0);
    send_item(item_of(OP_SUBMIT, Q_MAX, Q_MIN, Q_MAX, '0), 1'b0, '0);

    // drain, then watch for stray results
    settle_results();
    repeat (DEPTH + 8) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      $error("%0d lookup results never arrived", pending_lookups.size());
      fault_count++;
    end
    if (fault_count == 0)
      $display("vertex_dedup_table_tb: PASS");
    else
      $display("vertex_dedup_table_tb: FAIL");
    $finish;
  end

endmodule
